### rtl/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, constants and helpers for the motor feedback frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam int FRAME_LEN   = 16;
    localparam int CRC_LEN     = 14;
    localparam int COUNT_MAX   = 31;
    localparam int COUNT_W     = 5;
    localparam int BYTE_IDX_W  = 4;

    localparam logic [7:0]  HEAD0    = 8'hFD;
    localparam logic [7:0]  HEAD1    = 8'hEE;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // 2*pi/6.33 in Q16, rounded
    localparam logic signed [16:0] SCALE_Q16 = 17'sd65051;
    localparam int                 ROUND_BIAS = 32768;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CRC_ERR    = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_BAD_HEADER = 3'd4
    } status_t;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_IDLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         node_id;
        logic [2:0]         motor_mode;
        logic signed [7:0]  temperature;
        logic [2:0]         error_code;
        logic [11:0]        foot_force;
        logic signed [15:0] torque_q8;
        logic signed [15:0] joint_speed_q8;
        logic signed [31:0] joint_pos_q15;
    } out_item_t;

    // Classified frame handed from the front end to the scaling back end
    typedef struct packed {
        status_t            status;
        logic [3:0]         node_id;
        logic [2:0]         motor_mode;
        logic signed [7:0]  temperature;
        logic [2:0]         error_code;
        logic [11:0]        foot_force;
        logic signed [15:0] torque_q8;
        logic signed [15:0] speed_raw;
        logic signed [31:0] pos_raw;
    } frame_job_t;

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/mfp_front.sv
// ----------------------------------------------------------------------------
// mfp_front
// Collects frame bytes, runs the CRC and classifies the frame on line idle.
// ----------------------------------------------------------------------------
module mfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mfp_pkg::in_item_t   item,
    output logic                job_valid,
    input  logic                job_ready,
    output mfp_pkg::frame_job_t job
);

    logic [mfp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [15:0]                 crc_reg, crc_next;
    logic [7:0]                  bytes_reg [mfp_pkg::FRAME_LEN];

    logic             accept;
    logic             is_idle;
    mfp_pkg::status_t status;
    logic [15:0]      rx_crc;
    logic [15:0]      word;

    assign is_idle    = (item.op == mfp_pkg::OP_IDLE);
    assign item_ready = job_ready;
    assign accept     = item_valid && item_ready;
    assign job_valid  = item_valid && is_idle;

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (accept) begin
            if (is_idle) begin
                count_next = '0;
                crc_next   = '0;
            end else begin
                if (count_reg < mfp_pkg::CRC_LEN[mfp_pkg::COUNT_W-1:0])
                    crc_next = mfp_pkg::crc_byte(crc_reg, item.data_byte);
                if (count_reg < mfp_pkg::COUNT_MAX[mfp_pkg::COUNT_W-1:0])
                    count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            crc_reg   <= '0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // Store only the first sixteen bytes
    always_ff @(posedge clk)
    begin
        if (accept && !is_idle && (count_reg < mfp_pkg::FRAME_LEN[mfp_pkg::COUNT_W-1:0]))
            bytes_reg[count_reg[mfp_pkg::BYTE_IDX_W-1:0]] <= item.data_byte;
    end

    assign rx_crc = {bytes_reg[15], bytes_reg[14]};
    assign word   = {bytes_reg[13], bytes_reg[12]};

    always_comb
    begin
        priority if (count_reg == '0)
            status = mfp_pkg::ST_EMPTY;
        else if (count_reg != mfp_pkg::FRAME_LEN[mfp_pkg::COUNT_W-1:0])
            status = mfp_pkg::ST_BAD_LENGTH;
        else if (bytes_reg[0] != mfp_pkg::HEAD0 || bytes_reg[1] != mfp_pkg::HEAD1)
            status = mfp_pkg::ST_BAD_HEADER;
        else if (rx_crc != crc_reg)
            status = mfp_pkg::ST_CRC_ERR;
        else
            status = mfp_pkg::ST_OK;
    end

    always_comb
    begin
        job        = '0;
        job.status = status;
        if (status == mfp_pkg::ST_OK || status == mfp_pkg::ST_CRC_ERR) begin
            job.node_id     = bytes_reg[2][3:0];
            job.motor_mode  = bytes_reg[2][6:4];
            job.temperature = signed'(bytes_reg[11]);
            job.error_code  = word[2:0];
            job.foot_force  = word[14:3];
            job.torque_q8   = signed'({bytes_reg[4], bytes_reg[3]});
            job.speed_raw   = signed'({bytes_reg[6], bytes_reg[5]});
            job.pos_raw     = signed'({bytes_reg[10], bytes_reg[9], bytes_reg[8], bytes_reg[7]});
        end
    end

`ifndef SYNTHESIS
    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_idle) |=> (count_reg == '0 && crc_reg == '0))
        else $error("count or crc not cleared after idle");

    a_crc_frozen_past_14: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_idle && count_reg >= mfp_pkg::CRC_LEN[mfp_pkg::COUNT_W-1:0])
        |=> $stable(crc_reg))
        else $error("crc changed past byte 13");
`endif

endmodule

### rtl/mfp_queue.sv
// ----------------------------------------------------------------------------
// mfp_queue
// Short job queue between the front end and the scaling back end.
// ----------------------------------------------------------------------------
module mfp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mfp_pkg::frame_job_t push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mfp_pkg::frame_job_t pop_job
);

    mfp_pkg::frame_job_t               slots_reg [mfp_pkg::QUEUE_DEPTH];
    logic [mfp_pkg::QUEUE_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [mfp_pkg::QUEUE_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [mfp_pkg::QUEUE_CW-1:0]      count_reg, count_next;
    logic                              push, pop;

    assign push_ready = (count_reg != mfp_pkg::QUEUE_DEPTH[mfp_pkg::QUEUE_CW-1:0]);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slots_reg[rd_ptr_reg];

    function automatic logic [mfp_pkg::QUEUE_AW-1:0] ptr_inc(
        input logic [mfp_pkg::QUEUE_AW-1:0] p);
        if (p == mfp_pkg::QUEUE_AW'(mfp_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mfp_pkg::QUEUE_DEPTH[mfp_pkg::QUEUE_CW-1:0])
        else $error("queue count over depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");
`endif

endmodule

### rtl/mfp_back.sv
// ----------------------------------------------------------------------------
// mfp_back
// Scales speed and position by 2*pi/6.33 and registers the result item.
// ----------------------------------------------------------------------------
module mfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  mfp_pkg::frame_job_t job,
    output logic                result_valid,
    input  logic                result_ready,
    output mfp_pkg::out_item_t  result
);

    // multiply stage
    logic                       s1_valid_reg, s1_valid_next;
    mfp_pkg::frame_job_t        s1_job_reg;
    logic signed [32:0]         spd_prod_reg;
    logic signed [48:0]         pos_prod_reg;

    // output stage
    logic                       res_valid_reg, res_valid_next;
    mfp_pkg::out_item_t         res_reg;

    logic                       s1_take, s2_take;
    logic signed [32:0]         spd_sum;
    logic signed [48:0]         pos_sum;

    assign s2_take   = !res_valid_reg || result_ready;
    assign s1_take   = !s1_valid_reg || s2_take;
    assign job_ready = s1_take;

    assign s1_valid_next  = s1_take ? job_valid : s1_valid_reg;
    assign res_valid_next = s2_take ? s1_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && s1_take) begin
            s1_job_reg   <= job;
            spd_prod_reg <= 33'(job.speed_raw * mfp_pkg::SCALE_Q16);
            pos_prod_reg <= 49'(job.pos_raw * mfp_pkg::SCALE_Q16);
        end
    end

    // round half up, then drop the Q16 fraction
    assign spd_sum = spd_prod_reg + 33'(mfp_pkg::ROUND_BIAS);
    assign pos_sum = pos_prod_reg + 49'(mfp_pkg::ROUND_BIAS);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_take) begin
            res_reg.status         <= s1_job_reg.status;
            res_reg.node_id        <= s1_job_reg.node_id;
            res_reg.motor_mode     <= s1_job_reg.motor_mode;
            res_reg.temperature    <= s1_job_reg.temperature;
            res_reg.error_code     <= s1_job_reg.error_code;
            res_reg.foot_force     <= s1_job_reg.foot_force;
            res_reg.torque_q8      <= s1_job_reg.torque_q8;
            res_reg.joint_speed_q8 <= spd_sum[31:16];
            res_reg.joint_pos_q15  <= pos_sum[47:16];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_take) |=> (s1_valid_reg && $stable(pos_prod_reg)
                                        && $stable(spd_prod_reg)))
        else $error("multiply stage lost data while stalled");
`endif

endmodule

### rtl/motor_feedback_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser
// Parses 16-byte motor feedback frames with a CRC-16/KERMIT check.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  item    | item_valid / item_ready   | in_item_t: op, data_byte
//  result  | result_valid / result_ready | out_item_t: status and fields
//
//  One item per cycle while item_ready is high; data bytes never produce a result.
//  An idle item's result passes the queue write, the scaling multiply
//  and the output register in that order, the queue write being made
//  on the edge that accepts the item; a low result_ready can stall it.
//  item_ready drops only while the two-entry job queue is full.
//  Reset clears the byte count, CRC, queue and pipeline valids; no sweep.
// ----------------------------------------------------------------------------
module motor_feedback_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mfp_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output mfp_pkg::out_item_t result
);

    logic                q_in_valid, q_in_ready;
    mfp_pkg::frame_job_t q_in_job;
    logic                q_out_valid, q_out_ready;
    mfp_pkg::frame_job_t q_out_job;

    mfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (q_in_valid),
        .job_ready  (q_in_ready),
        .job        (q_in_job)
    );

    mfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_job   (q_in_job),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_job    (q_out_job)
    );

    mfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_out_valid),
        .job_ready    (q_out_ready),
        .job          (q_out_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
